FILE: rtl/lbps_pkg.sv
// Shared types, request codes and helper functions for the LED blink
// priority sequencer. No dependencies; every other RTL file imports it.
`default_nettype none

package lbps_pkg;

  // Field widths
  localparam int unsigned LenW       = 17;
  localparam int unsigned MsW        = 16;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned InTdataW   = 88;
  localparam int unsigned OutTdataW  = 8;

  // Default tick period in milliseconds
  localparam int unsigned TickMsDefault = 50;

  // Request kinds carried on the input tuser
  typedef enum logic [ReqW-1:0] {
    REQ_TICK = 2'd0,
    REQ_BASE = 2'd1,
    REQ_OVR  = 2'd2
  } req_e;

  // One input request after the input register
  typedef struct packed {
    req_e                   kind;
    logic                   red;
    logic                   green;
    logic                   blue;
    logic signed [LenW-1:0] base_on;
    logic signed [LenW-1:0] base_off;
    logic [MsW-1:0]         on_ms;
    logic [MsW-1:0]         off_ms;
    logic [MsW-1:0]         cycles;
  } req_t;

  // Drive and status seen by the user after a request
  typedef struct packed {
    logic ovr;
    logic timer;
    logic blue;
    logic green;
    logic red;
    logic lamp;
  } status_t;

  // Drive word: bit0 lamp, bit1 red, bit2 green, bit3 blue.
  // Override level shows white; no color at all only clears the lamp.
  function automatic logic [3:0] apply_colors(input logic       level,
                                              input logic [2:0] colors,
                                              input logic [3:0] drive);
    logic [2:0] c;
    logic [3:0] res;
    c   = level ? 3'b111 : colors;
    res = drive;
    if (c == 3'b000) begin
      res[0] = 1'b0;
    end else begin
      res = {c, 1'b1};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lbps_div_const.sv
// Unsigned 16-bit divide by a constant, done as a multiply by a rounded-up
// reciprocal that is exact over the whole input range. Uses lbps_pkg.
`default_nettype none

module lbps_div_const #(
  parameter int unsigned DIVISOR = lbps_pkg::TickMsDefault
) (
  input  wire logic [lbps_pkg::MsW-1:0] dividend_i,
  output logic      [lbps_pkg::MsW-1:0] quotient_o
);
  import lbps_pkg::*;

  // Shift of N plus ceil(log2 D) bits makes the ceiling reciprocal exact
  localparam int unsigned Shift = MsW + $clog2(DIVISOR);
  localparam int unsigned ProdW = Shift + MsW;
  localparam int unsigned MultW = MsW + 2;
  localparam longint unsigned MultFull =
    ((64'd1 << Shift) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MultW-1:0] Mult = MultW'(MultFull);

  logic [ProdW-1:0] prod;

  // Multiply and keep the integer part
  assign prod       = ProdW'(dividend_i) * ProdW'(Mult);
  assign quotient_o = prod[Shift +: MsW];

endmodule

`default_nettype wire

FILE: rtl/lbps_core.sv
// Sequencer state and its combinational update for base, override and tick
// requests. Uses lbps_pkg and two lbps_div_const instances.
`default_nettype none

module lbps_core #(
  parameter int unsigned TICK_MS = lbps_pkg::TickMsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire lbps_pkg::req_t   req_i,
  output lbps_pkg::status_t     status_o
);
  import lbps_pkg::*;

  logic                   level_q, level_d;
  logic [2:0]             colors_q, colors_d;
  logic signed [LenW-1:0] base_on_q, base_on_d;
  logic signed [LenW-1:0] base_off_q, base_off_d;
  logic signed [LenW-1:0] ovr_on_q, ovr_on_d;
  logic signed [LenW-1:0] ovr_off_q, ovr_off_d;
  logic signed [LenW-1:0] cycles_q, cycles_d;
  logic signed [LenW-1:0] on_cnt_q, on_cnt_d;
  logic signed [LenW-1:0] off_cnt_q, off_cnt_d;
  logic [3:0]             drive_q, drive_d;
  logic                   tick_en_q, tick_en_d;

  logic [MsW-1:0]         on_ticks, off_ticks;
  logic signed [LenW-1:0] on_len, off_len;

  // Convert override times from ms to ticks
  lbps_div_const #(.DIVISOR(TICK_MS)) u_div_on (
    .dividend_i (req_i.on_ms),
    .quotient_o (on_ticks)
  );

  lbps_div_const #(.DIVISOR(TICK_MS)) u_div_off (
    .dividend_i (req_i.off_ms),
    .quotient_o (off_ticks)
  );

  // Lengths of the level now selected
  assign on_len  = level_q ? ovr_on_q  : base_on_q;
  assign off_len = level_q ? ovr_off_q : base_off_q;

  // Next state for the request in the input register
  always_comb begin
    level_d    = level_q;
    colors_d   = colors_q;
    base_on_d  = base_on_q;
    base_off_d = base_off_q;
    ovr_on_d   = ovr_on_q;
    ovr_off_d  = ovr_off_q;
    cycles_d   = cycles_q;
    on_cnt_d   = on_cnt_q;
    off_cnt_d  = off_cnt_q;
    drive_d    = drive_q;
    tick_en_d  = tick_en_q;
    case (req_i.kind)
      REQ_TICK: begin
        if (tick_en_q) begin
          if (on_len < 17'sd0 || off_len < 17'sd0) begin
            // Fixed state: fall back to base and stop where it says so
            level_d = 1'b0;
            if (base_off_q == -17'sd1) begin
              drive_d[0] = 1'b0;
              tick_en_d  = 1'b0;
            end else if (base_on_q == -17'sd1) begin
              drive_d[0] = 1'b1;
              drive_d    = apply_colors(1'b0, colors_q, drive_d);
              tick_en_d  = 1'b0;
            end
          end else if (on_cnt_q != 17'sd0) begin
            // On phase: light the lamp and count down
            drive_d    = apply_colors(level_q, colors_q, drive_q);
            drive_d[0] = 1'b1;
            on_cnt_d   = on_cnt_q - 17'sd1;
            if (on_cnt_d <= 17'sd0) begin
              off_cnt_d = off_len;
            end
          end else if (off_cnt_q != 17'sd0) begin
            // Off phase: dark lamp, count down, close one blink cycle
            drive_d[0] = 1'b0;
            off_cnt_d  = off_cnt_q - 17'sd1;
            if (off_cnt_d <= 17'sd0) begin
              if (level_q) begin
                cycles_d = cycles_q - 17'sd1;
                if (cycles_d <= 17'sd0) begin
                  level_d = 1'b0;
                end
              end
              on_cnt_d = level_d ? ovr_on_q : base_on_q;
            end
          end
        end
      end
      REQ_BASE: begin
        colors_d   = {req_i.blue, req_i.green, req_i.red};
        base_on_d  = req_i.base_on;
        base_off_d = req_i.base_off;
        // Reload counters only while the override is not selected
        if (!level_q) begin
          on_cnt_d  = req_i.base_on;
          off_cnt_d = req_i.base_off;
          drive_d   = apply_colors(1'b0, colors_d, drive_q);
        end
        tick_en_d = 1'b1;
      end
      REQ_OVR: begin
        level_d   = 1'b1;
        ovr_on_d  = {1'b0, on_ticks};
        ovr_off_d = {1'b0, off_ticks};
        cycles_d  = {1'b0, req_i.cycles};
        on_cnt_d  = {1'b0, on_ticks};
        off_cnt_d = {1'b0, off_ticks};
        tick_en_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Commit the update when the request moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 1'b0;
      colors_q   <= 3'b000;
      base_on_q  <= 17'sd0;
      base_off_q <= -17'sd1;
      ovr_on_q   <= 17'sd0;
      ovr_off_q  <= 17'sd0;
      cycles_q   <= 17'sd0;
      on_cnt_q   <= 17'sd0;
      off_cnt_q  <= -17'sd1;
      drive_q    <= 4'b0000;
      tick_en_q  <= 1'b0;
    end else if (step_i) begin
      level_q    <= level_d;
      colors_q   <= colors_d;
      base_on_q  <= base_on_d;
      base_off_q <= base_off_d;
      ovr_on_q   <= ovr_on_d;
      ovr_off_q  <= ovr_off_d;
      cycles_q   <= cycles_d;
      on_cnt_q   <= on_cnt_d;
      off_cnt_q  <= off_cnt_d;
      drive_q    <= drive_d;
      tick_en_q  <= tick_en_d;
    end
  end

  // Report the state after this request
  assign status_o.lamp  = drive_d[0];
  assign status_o.red   = drive_d[1];
  assign status_o.green = drive_d[2];
  assign status_o.blue  = drive_d[3];
  assign status_o.timer = tick_en_d;
  assign status_o.ovr   = level_d;

`ifndef NO_ASSERTIONS
  // An override request always selects the override level
  a_ovr_selects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.kind == REQ_OVR |=> level_q)
    else $error("override request did not select override level");

  // A base request always starts the timer
  a_base_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.kind == REQ_BASE |=> tick_en_q)
    else $error("base request did not start the timer");

  // A tick while stopped leaves counters and drives alone
  a_stopped_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.kind == REQ_TICK && !tick_en_q |=>
      $stable(on_cnt_q) && $stable(off_cnt_q) && $stable(drive_q))
    else $error("tick changed state while timer stopped");

  // The timer only stops on a tick
  a_stop_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(tick_en_q) |-> $past(step_i && req_i.kind == REQ_TICK))
    else $error("timer stopped without a tick");
`endif

endmodule

`default_nettype wire

FILE: rtl/led_blink_priority_sequencer_top.sv
// Top level of the LED blink priority sequencer: stream ports, input
// register and result register around lbps_core. Uses lbps_pkg.
`default_nettype none

// RGB LED blink sequencer with a base and an override level. Every request
// (tick, set base pattern, start override) yields one status result: the
// lamp enable, the three color drives, the timer state and the selected
// level after the request. One request is taken per clock cycle while the
// output side is ready; a request waits in the input register while the
// state update and the ms-to-tick conversion (a constant reciprocal
// multiply) run, and its result is loaded into the result register as
// the request advances, while a new request can enter the input register.
// The whole update is a single register-to-register pass over the stored
// state. A stalled output holds the result and backs up into the input
// register. No memory and no start-up clearing.

module led_blink_priority_sequencer_top #(
  parameter int unsigned TICK_MS = lbps_pkg::TickMsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // red[0], green[1], blue[2], base_on_ticks[19:3], base_off_ticks[36:20],
  // ovr_on_ms[52:37], ovr_off_ms[68:53], ovr_cycles[84:69], zero[87:85]
  input  wire logic [lbps_pkg::InTdataW-1:0]     s_axis_tdata_i,
  // req_type[1:0]
  input  wire logic [lbps_pkg::ReqW-1:0]         s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // lamp_enable[0], red_drive[1], green_drive[2], blue_drive[3],
  // timer_running[4], override_active[5], zero[7:6]
  output logic [lbps_pkg::OutTdataW-1:0]         m_axis_tdata_o
);
  import lbps_pkg::*;

  logic    in_valid_q;
  req_t    req_q, req_d;
  logic    out_valid_q;
  status_t out_q;
  status_t status;
  logic    step;
  logic    in_fire;

  // Advance when the result register is free or being emptied
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the request
  always_comb begin
    req_d.kind     = req_e'(s_axis_tuser_i);
    req_d.red      = s_axis_tdata_i[0];
    req_d.green    = s_axis_tdata_i[1];
    req_d.blue     = s_axis_tdata_i[2];
    req_d.base_on  = s_axis_tdata_i[19:3];
    req_d.base_off = s_axis_tdata_i[36:20];
    req_d.on_ms    = s_axis_tdata_i[52:37];
    req_d.off_ms   = s_axis_tdata_i[68:53];
    req_d.cycles   = s_axis_tdata_i[84:69];
  end

  // Hold the request in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
  end

  lbps_core #(.TICK_MS(TICK_MS)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .req_i    (req_q),
    .status_o (status)
  );

  // Hold the result until the output side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.ovr, out_q.timer, out_q.blue,
                            out_q.green, out_q.red, out_q.lamp};

endmodule

`default_nettype wire

FILE: test/led_blink_priority_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_blink_priority_sequencer_top: sends tick,
// base pattern and override requests and checks every status result.
// Depends on lbps_pkg and the sequencer RTL.

module led_blink_priority_sequencer_top_tb;
  import lbps_pkg::*;

  localparam int unsigned TickMs        = TickMsDefault;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;
  localparam int unsigned HoldOffCycles = 40;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxReported   = 10;

  // One request as the sender sees it
  typedef struct packed {
    logic [ReqW-1:0]        kind;
    logic                   red;
    logic                   green;
    logic                   blue;
    logic signed [LenW-1:0] on_ticks;
    logic signed [LenW-1:0] off_ticks;
    logic [MsW-1:0]         on_ms;
    logic [MsW-1:0]         off_ms;
    logic [MsW-1:0]         cycles;
  } blink_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i;
  logic [ReqW-1:0]      s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  // Sequencer state tracked by the bench
  logic                   sel_ovr;
  logic [2:0]             pat_rgb;
  logic signed [LenW-1:0] pat_on;
  logic signed [LenW-1:0] pat_off;
  logic signed [LenW-1:0] ovr_on;
  logic signed [LenW-1:0] ovr_off;
  logic signed [LenW-1:0] ovr_left;
  logic signed [LenW-1:0] on_left;
  logic signed [LenW-1:0] off_left;
  logic [3:0]             drv;
  logic                   timer_en;

  logic [OutTdataW-1:0] status_q[$];
  string status_field [OutTdataW] = '{"lamp_enable", "red_drive", "green_drive",
                                      "blue_drive", "timer_running",
                                      "override_active", "pad6", "pad7"};

  bit tx_steady;
  bit rx_steady;
  int unsigned hold_off_reqs = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_tick;
  int unsigned n_base;
  int unsigned n_ovr;
  int unsigned n_unused;

  always #5 clk_i = ~clk_i;

  led_blink_priority_sequencer_top #(
    .TICK_MS(TickMs)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // ---------------------------------------------------------------------
  // Blink sequencer prediction
  // ---------------------------------------------------------------------

  function automatic void clear_sequencer();
    sel_ovr  = 1'b0;
    pat_rgb  = 3'b000;
    pat_on   = '0;
    pat_off  = -17'sd1;
    ovr_on   = '0;
    ovr_off  = '0;
    ovr_left = '0;
    on_left  = '0;
    off_left = -17'sd1;
    drv      = 4'b0000;
    timer_en = 1'b0;
  endfunction

  // Show white on the override level; no color at all only drops the lamp
  function automatic void paint_drive();
    logic [2:0] c;
    c = sel_ovr ? 3'b111 : pat_rgb;
    if (c == 3'b000) begin
      drv[0] = 1'b0;
    end else begin
      drv = {c, 1'b1};
    end
  endfunction

  function automatic void advance_tick();
    logic signed [LenW-1:0] on_len;
    logic signed [LenW-1:0] off_len;
    on_len  = sel_ovr ? ovr_on : pat_on;
    off_len = sel_ovr ? ovr_off : pat_off;
    if (on_len < 0 || off_len < 0) begin
      // Fixed state: fall back to base, stop only on stay-off or stay-on
      sel_ovr = 1'b0;
      if (pat_off == -1) begin
        drv[0]   = 1'b0;
        timer_en = 1'b0;
      end else if (pat_on == -1) begin
        drv[0] = 1'b1;
        paint_drive();
        timer_en = 1'b0;
      end
    end else if (on_left != 0) begin
      paint_drive();
      drv[0]  = 1'b1;
      on_left = on_left - 17'sd1;
      if (on_left <= 0) begin
        off_left = off_len;
      end
    end else if (off_left != 0) begin
      drv[0]   = 1'b0;
      off_left = off_left - 17'sd1;
      if (off_left <= 0) begin
        if (sel_ovr) begin
          ovr_left = ovr_left - 17'sd1;
          if (ovr_left <= 0) begin
            sel_ovr = 1'b0;
          end
        end
        on_left = sel_ovr ? ovr_on : pat_on;
      end
    end
  endfunction

  // Apply one request and return the status word it should produce
  function automatic logic [OutTdataW-1:0] predict_status(input blink_req_t r);
    if (r.kind == REQ_TICK) begin
      if (timer_en) begin
        advance_tick();
      end
    end else if (r.kind == REQ_BASE) begin
      pat_rgb = {r.blue, r.green, r.red};
      pat_on  = r.on_ticks;
      pat_off = r.off_ticks;
      if (!sel_ovr) begin
        on_left  = pat_on;
        off_left = pat_off;
        paint_drive();
      end
      timer_en = 1'b1;
    end else if (r.kind == REQ_OVR) begin
      sel_ovr  = 1'b1;
      ovr_on   = LenW'(r.on_ms / TickMs);
      ovr_off  = LenW'(r.off_ms / TickMs);
      ovr_left = {1'b0, r.cycles};
      on_left  = ovr_on;
      off_left = ovr_off;
      timer_en = 1'b1;
    end
    return {2'b00, sel_ovr, timer_en, drv};
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly short lengths so blink phases complete; some fixed and some long
  function automatic logic signed [LenW-1:0] rand_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) begin
      return -17'sd1;
    end else if (p < 80) begin
      return LenW'($urandom_range(0, 6));
    end else if (p < 95) begin
      return LenW'($urandom_range(7, 40));
    end
    return LenW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [MsW-1:0] rand_ms();
    if ($urandom_range(0, 99) < 80) begin
      return MsW'($urandom_range(0, 400));
    end
    return MsW'($urandom);
  endfunction

  function automatic logic [MsW-1:0] rand_cycles();
    if ($urandom_range(0, 99) < 75) begin
      return MsW'($urandom_range(0, 4));
    end
    return MsW'($urandom);
  endfunction

  function automatic blink_req_t rand_fields(input logic [ReqW-1:0] kind);
    blink_req_t r;
    r.kind      = kind;
    r.red       = 1'($urandom_range(0, 1));
    r.green     = 1'($urandom_range(0, 1));
    r.blue      = 1'($urandom_range(0, 1));
    r.on_ticks  = rand_len();
    r.off_ticks = rand_len();
    r.on_ms     = rand_ms();
    r.off_ms    = rand_ms();
    r.cycles    = rand_cycles();
    return r;
  endfunction

  function automatic blink_req_t rand_request();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) begin
      return rand_fields(REQ_TICK);
    end else if (p < 80) begin
      return rand_fields(REQ_BASE);
    end else if (p < 95) begin
      return rand_fields(REQ_OVR);
    end
    return rand_fields(ReqUnused);
  endfunction

  // Offer one request, hold it until taken, then log its expected status
  task automatic send_request(input blink_req_t r);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, r.cycles, r.off_ms, r.on_ms, r.off_ticks, r.on_ticks,
                        r.blue, r.green, r.red};
    s_axis_tuser_i  <= r.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    status_q.push_back(predict_status(r));
    case (r.kind)
      REQ_TICK: n_tick++;
      REQ_BASE: n_base++;
      REQ_OVR:  n_ovr++;
      default:  n_unused++;
    endcase
  endtask

  task automatic send_tick();
    send_request(rand_fields(REQ_TICK));
  endtask

  task automatic send_base(input logic [2:0] rgb, input logic signed [LenW-1:0] on_t,
                           input logic signed [LenW-1:0] off_t);
    blink_req_t r;
    r           = rand_fields(REQ_BASE);
    {r.blue, r.green, r.red} = rgb;
    r.on_ticks  = on_t;
    r.off_ticks = off_t;
    send_request(r);
  endtask

  task automatic send_ovr(input logic [MsW-1:0] on_ms, input logic [MsW-1:0] off_ms,
                          input logic [MsW-1:0] cycles);
    blink_req_t r;
    r        = rand_fields(REQ_OVR);
    r.on_ms  = on_ms;
    r.off_ms = off_ms;
    r.cycles = cycles;
    send_request(r);
  endtask

  function automatic void note_mismatch(input string what, input logic [OutTdataW-1:0] want,
                                        input logic [OutTdataW-1:0] got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("[%0t] %s: expected %b, got %b", $realtime, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Tick while stopped and the unused request code leave the state alone
  task automatic test_idle_requests();
    send_tick();
    send_request(rand_fields(ReqUnused));
  endtask

  task automatic test_base_patterns();
    // Plain red blink, two on and one off
    send_base(3'b001, 17'sd2, 17'sd1);
    repeat (4) send_tick();
    // No color: lamp drops, drives hold; then both counters run out
    send_base(3'b000, 17'sd1, 17'sd0);
    repeat (2) send_tick();
    // Longest lengths, all colors
    send_base(3'b111, 17'sd65535, 17'sd65535);
    send_tick();
    // Stay on, then stay off
    send_base(3'b010, -17'sd1, 17'sd3);
    send_tick();
    send_base(3'b100, 17'sd4, -17'sd1);
    send_tick();
  endtask

  task automatic test_override();
    // Zero cycles: first finished off phase reverts to base
    send_ovr(16'd100, 16'd99, 16'd0);
    repeat (4) send_tick();
    // Largest override, then a base request that must not reload counters
    send_ovr(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_base(3'b001, 17'sd3, 17'sd3);
    send_tick();
  endtask

  // Hold the receiver off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_off_reqs++;
    tx_steady    = 1'b1;
    repeat (16) send_request(rand_request());
    tx_steady    = 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // Switch between idling and back-to-back stretches
      if (i % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_request(rand_request());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Accept results after a random stall, or after a long hold-off on request
  initial begin : rx_ready_gen
    int unsigned stall;
    int unsigned hold_off_done;
    hold_off_done   = 0;
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_reqs != hold_off_done) begin
        hold_off_done++;
        stall = HoldOffCycles;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 5);
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Compare each result with the oldest expected status
  always @(posedge clk_i) begin : check_results
    logic [OutTdataW-1:0] want;
    string bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (status_q.size() == 0) begin
        note_mismatch("result with no request pending", 'x, m_axis_tdata_o);
      end else begin
        want = status_q.pop_front();
        bad  = "";
        for (int b = 0; b < OutTdataW; b++) begin
          if (m_axis_tdata_o[b] !== want[b]) begin
            bad = {bad, " ", status_field[b]};
          end
        end
        if (bad != "") begin
          note_mismatch({"status differs in", bad}, want, m_axis_tdata_o);
        end
      end
    end
  end

  // Stop the run when no request or result moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog: no request or result moved for %0d cycles", WatchdogLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_TICK;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    n_tick          = 0;
    n_base          = 0;
    n_ovr           = 0;
    n_unused        = 0;
    clear_sequencer();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_requests();
    test_base_patterns();
    test_override();
    test_backpressure();
    test_random_traffic(410);
    drain_results();

    $display("Sent %0d ticks, %0d base patterns, %0d overrides, %0d unused codes",
             n_tick, n_base, n_ovr, n_unused);
    $display("Checked %0d status results, %0d mismatching", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lbps_pkg.sv
rtl/lbps_div_const.sv
rtl/lbps_core.sv
rtl/led_blink_priority_sequencer_top.sv
test/led_blink_priority_sequencer_top_tb.sv
